>>> src/cqh_pkg.sv
// cqh_pkg: shared constants, types and index packing for the color histogram
// no dependencies; compiled first
`default_nettype none

package cqh_pkg;

  localparam int INDEX_BITS = 6;
  localparam int COUNT_BITS = 24;
  localparam int NUM_BINS   = 1 << INDEX_BITS;
  localparam int NB_W       = 3;     // width of a used-index-bit count
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BITS_KEPT  = 2'd0,
    REG_COLOR_MODE = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_PIX,
    ST_DRAIN,
    ST_RD,
    ST_LOAD
  } cqh_state_t;

  typedef struct packed {
    logic pix_en;    // pixel channel open
    logic emit_rd;   // read side addressed by the emit pointer
    logic out_load;  // load output register, step pointer
  } cqh_cmd_t;

  typedef struct packed {
    logic last_acc;  // last pixel accepted this cycle
    logic out_free;  // output register can take a word
    logic emit_last; // emit pointer sits on the final bin in use
  } cqh_stat_t;

  // bits kept per component after limiting to what the index can hold
  function automatic logic [1:0] eff_bits(input logic [1:0] bits_kept,
                                          input logic color_mode);
    logic [1:0] k;
    begin
      k = (bits_kept == 2'd0) ? 2'd1 : bits_kept;
      if (color_mode && k > 2'd2) k = 2'd2;
      eff_bits = k;
    end
  endfunction

  // total number of index bits in use
  function automatic logic [NB_W-1:0] used_bits(input logic [1:0] bits_kept,
                                                input logic color_mode);
    logic [1:0] k;
    begin
      k = eff_bits(bits_kept, color_mode);
      if (color_mode) used_bits = (k == 2'd2) ? NB_W'(6) : NB_W'(3);
      else            used_bits = NB_W'(k);
    end
  endfunction

  // red high, then green, then blue; gray uses the first component only
  function automatic logic [INDEX_BITS-1:0] pack_index(input logic [7:0] r,
                                                       input logic [7:0] g,
                                                       input logic [7:0] b,
                                                       input logic [1:0] bits_kept,
                                                       input logic color_mode);
    logic [1:0] k;
    begin
      k = eff_bits(bits_kept, color_mode);
      if (color_mode) begin
        if (k == 2'd2) pack_index = INDEX_BITS'({r[7:6], g[7:6], b[7:6]});
        else           pack_index = INDEX_BITS'({r[7], g[7], b[7]});
      end else begin
        case (k)
          2'd2:    pack_index = INDEX_BITS'(r[7:6]);
          2'd3:    pack_index = INDEX_BITS'(r[7:5]);
          default: pack_index = INDEX_BITS'(r[7]);
        endcase
      end
    end
  endfunction

endpackage

`default_nettype wire

>>> src/cqh_pix_if.sv
// cqh_pix_if: pixel word channel, valid/ready with one pixel as payload
// depends on nothing
`default_nettype none

interface cqh_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_or_gray;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;

  modport source (output valid, red_or_gray, green, blue, last_pixel, input ready);
  modport sink   (input valid, red_or_gray, green, blue, last_pixel, output ready);
endinterface

`default_nettype wire

>>> src/cqh_bin_if.sv
// cqh_bin_if: histogram bin word channel, valid/ready with one bin as payload
// depends on cqh_pkg
`default_nettype none

interface cqh_bin_if
  import cqh_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] bin_index;
  logic [COUNT_BITS-1:0] bin_count;
  logic                  last_bin;

  modport source (output valid, bin_index, bin_count, last_bin, input ready);
  modport sink   (input valid, bin_index, bin_count, last_bin, output ready);
endinterface

`default_nettype wire

>>> src/cqh_cfg_if.sv
// cqh_cfg_if: register write channel, valid/ready with index and data
// depends on cqh_pkg
`default_nettype none

interface cqh_cfg_if
  import cqh_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/cqh_ram.sv
// cqh_ram: generic single write, single read RAM with registered read data
// no package dependencies; read during write to one address returns old data
`default_nettype none

module cqh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/cqh_datapath.sv
// cqh_datapath: config registers, bin counter RAM with valid bits, increment
// stage with forwarding, emit pointer and output register; uses cqh_pkg, cqh_ram
`default_nettype none

module cqh_datapath
  import cqh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  cqh_pix_if.sink       pix,
  cqh_bin_if.source     bin,
  cqh_cfg_if.sink       cfg,
  input  wire cqh_cmd_t cmd,
  output cqh_stat_t     stat
);

  logic [1:0]            bits_kept_r;
  logic                  color_mode_r;

  logic [NUM_BINS-1:0]   valid_r;
  logic                  rd_vld_r;
  logic [COUNT_BITS-1:0] ram_q;

  logic                  s1_vld_r;
  logic [INDEX_BITS-1:0] s1_idx_r;
  logic                  fwd_vld_r;
  logic [INDEX_BITS-1:0] fwd_idx_r;
  logic [COUNT_BITS-1:0] fwd_val_r;

  logic [INDEX_BITS-1:0] ptr_r;
  logic                  out_vld_r;
  logic [INDEX_BITS-1:0] out_idx_r;
  logic [COUNT_BITS-1:0] out_cnt_r;
  logic                  out_last_r;

  logic [INDEX_BITS-1:0] pix_idx;
  logic [INDEX_BITS-1:0] raddr;
  logic                  pix_acc;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [NB_W-1:0]       nb;
  logic [INDEX_BITS:0]   used_m1;

  assign cfg.ready = 1'b1;
  assign pix.ready = cmd.pix_en;
  assign pix_acc   = pix.valid && cmd.pix_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_kept_r  <= 2'd2;
      color_mode_r <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_BITS_KEPT:  bits_kept_r  <= cfg.data[1:0];
        REG_COLOR_MODE: color_mode_r <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign pix_idx = pack_index(pix.red_or_gray, pix.green, pix.blue,
                              bits_kept_r, color_mode_r);
  assign raddr   = cmd.emit_rd ? ptr_r : pix_idx;

  cqh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_idx_r),
    .wdata (new_cnt),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // a never-written entry reads as zero
  assign rd_cnt  = rd_vld_r ? ram_q : '0;
  // the previous pixel's write landed at the same edge as this read
  assign cur_cnt = (fwd_vld_r && fwd_idx_r == s1_idx_r) ? fwd_val_r : rd_cnt;
  assign new_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    rd_vld_r  <= valid_r[raddr];
    s1_idx_r  <= pix_idx;
    fwd_idx_r <= s1_idx_r;
    fwd_val_r <= new_cnt;
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= pix_acc;
      fwd_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.out_load && stat.emit_last) begin
      valid_r <= '0;
    end else if (s1_vld_r) begin
      valid_r[s1_idx_r] <= 1'b1;
    end
  end

  assign nb      = used_bits(bits_kept_r, color_mode_r);
  assign used_m1 = ((INDEX_BITS+1)'(1) << nb) - (INDEX_BITS+1)'(1);

  assign stat.last_acc  = pix_acc && pix.last_pixel;
  assign stat.out_free  = !out_vld_r || bin.ready;
  assign stat.emit_last = ({1'b0, ptr_r} == used_m1);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_idx_r  <= ptr_r;
      out_cnt_r  <= rd_cnt;
      out_last_r <= stat.emit_last;
    end
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      ptr_r     <= '0;
    end else begin
      if (cmd.out_load)   out_vld_r <= 1'b1;
      else if (bin.ready) out_vld_r <= 1'b0;
      if (cmd.out_load) ptr_r <= stat.emit_last ? '0 : ptr_r + INDEX_BITS'(1);
    end
  end

  assign bin.valid     = out_vld_r;
  assign bin.bin_index = out_idx_r;
  assign bin.bin_count = out_cnt_r;
  assign bin.last_bin  = out_last_r;

endmodule

`default_nettype wire

>>> src/cqh_ctrl.sv
// cqh_ctrl: state machine sequencing pixel counting and histogram readout
// uses cqh_pkg command and status types
`default_nettype none

module cqh_ctrl
  import cqh_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cqh_stat_t stat,
  output cqh_cmd_t       cmd
);

  cqh_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_PIX;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_PIX: begin
        cmd.pix_en = 1'b1;
        if (stat.last_acc) state_nxt = ST_DRAIN;
      end
      // let the last pixel's write land before reading back
      ST_DRAIN: state_nxt = ST_RD;
      ST_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.emit_rd = 1'b1;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = stat.emit_last ? ST_PIX : ST_RD;
        end
      end
      default: state_nxt = ST_PIX;
    endcase
  end

endmodule

`default_nettype wire

>>> src/color_quantized_histogram_core.sv
// color_quantized_histogram_core: top level of the quantized color histogram
// uses cqh_pkg, the three channel interfaces, cqh_ctrl and cqh_datapath
//
// Channels: in_pix takes one pixel word (red_or_gray, green, blue,
// last_pixel); out_bin gives one word per histogram bin (bin_index,
// bin_count, last_bin); cfg_wr writes bits_kept (index 0) and color_mode
// (index 1) and is always ready. Write config only between images.
// Pixels are taken one per cycle while in_pix.ready is high; a pixel's count
// lands in the bin RAM at the edge after acceptance, set by the registered
// RAM read plus increment. The pixel marked last closes the image: in_pix.ready
// drops, and a drain state and a read state come before the first bin word
// is loaded. The bins in use (8 or 64 in RGB, 2, 4 or 8 in gray) come in
// ascending order, each word through a read state and a load state, set by
// the single RAM read port and output register. The last word carries last_bin;
// the store is cleared as it is loaded and in_pix.ready returns the next
// cycle, while that word may still wait in the output register.
// A stalled receiver holds the readout; the output word stays stable.
// Reset empties all bins at once through per-bin valid bits, no clearing
// pass; bits_kept resets to 2 and color_mode to RGB.
`default_nettype none

module color_quantized_histogram_core
  import cqh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  cqh_pix_if.sink   in_pix,
  cqh_bin_if.source out_bin,
  cqh_cfg_if.sink   cfg_wr
);

  cqh_cmd_t  cmd;
  cqh_stat_t stat;

  cqh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  cqh_datapath u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .pix   (in_pix),
    .bin   (out_bin),
    .cfg   (cfg_wr),
    .cmd   (cmd),
    .stat  (stat)
  );

  a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    stat.last_acc |=> !in_pix.ready)
    else $error("pixel channel open right after last pixel");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten while full");

  a_one_read_user: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.pix_en && cmd.emit_rd))
    else $error("pixel and readout both drive the read port");

  a_reopen_after_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && stat.emit_last) |=> cmd.pix_en)
    else $error("pixel channel not reopened after final bin");

endmodule

`default_nettype wire
